// ===== hw/rtl/aabb_ct_pkg.sv =====
// shared types and constants of the box contact tracker
`timescale 1ns / 1ps
`default_nettype none

package aabb_ct_pkg;

  localparam int unsigned ID_W   = 6;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned SIZE_W = 23;
  localparam int unsigned CMP_W  = 28;
  localparam int unsigned EV_W   = 2;

  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_e;

  // write-back of one contact bit
  typedef struct packed {
    logic wr_en;
    logic touching;
  } pair_update_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_ct_if.sv =====
// valid/ready channels for pair transactions and their results
`timescale 1ns / 1ps
`default_nettype none

interface aabb_ct_pair_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     opcode;
  logic        [aabb_ct_pkg::ID_W-1:0]      left_id;
  logic        [aabb_ct_pkg::ID_W-1:0]      right_id;
  logic signed [aabb_ct_pkg::POS_W-1:0]     left_x;
  logic signed [aabb_ct_pkg::POS_W-1:0]     left_y;
  logic        [aabb_ct_pkg::SIZE_W-1:0]    left_w;
  logic        [aabb_ct_pkg::SIZE_W-1:0]    left_h;
  logic signed [aabb_ct_pkg::POS_W-1:0]     right_x;
  logic signed [aabb_ct_pkg::POS_W-1:0]     right_y;
  logic        [aabb_ct_pkg::SIZE_W-1:0]    right_w;
  logic        [aabb_ct_pkg::SIZE_W-1:0]    right_h;

  modport source (
    output valid, opcode, left_id, right_id, left_x, left_y, left_w, left_h,
           right_x, right_y, right_w, right_h,
    input  ready
  );

  modport sink (
    input  valid, opcode, left_id, right_id, left_x, left_y, left_w, left_h,
           right_x, right_y, right_w, right_h,
    output ready
  );
endinterface

interface aabb_ct_result_if;
  logic                           valid;
  logic                           ready;
  logic [aabb_ct_pkg::EV_W-1:0]   contact_event;
  logic                           boxes_overlap;

  modport source (output valid, contact_event, boxes_overlap, input ready);
  modport sink   (input valid, contact_event, boxes_overlap, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/aabb_ct_axis.sv =====
// strict overlap test of two boxes along one axis in doubled fixed point
`timescale 1ns / 1ps
`default_nettype none

module aabb_ct_axis (
  input  wire logic signed [aabb_ct_pkg::POS_W-1:0]  left_pos_i,
  input  wire logic        [aabb_ct_pkg::SIZE_W-1:0] left_size_i,
  input  wire logic signed [aabb_ct_pkg::POS_W-1:0]  right_pos_i,
  input  wire logic        [aabb_ct_pkg::SIZE_W-1:0] right_size_i,
  output logic                                       overlap_o
);

  localparam int unsigned PadPos  = aabb_ct_pkg::CMP_W - aabb_ct_pkg::POS_W - 1;
  localparam int unsigned PadSize = aabb_ct_pkg::CMP_W - aabb_ct_pkg::SIZE_W;

  logic signed [aabb_ct_pkg::CMP_W-1:0] left_c;
  logic signed [aabb_ct_pkg::CMP_W-1:0] right_c;
  logic signed [aabb_ct_pkg::CMP_W-1:0] diff;
  logic signed [aabb_ct_pkg::CMP_W-1:0] diff_neg;
  logic signed [aabb_ct_pkg::CMP_W-1:0] size_sum;

  // doubled centers
  assign left_c  = $signed({{PadPos{left_pos_i[aabb_ct_pkg::POS_W-1]}}, left_pos_i, 1'b0})
                 + $signed({{PadSize{1'b0}}, left_size_i});
  assign right_c = $signed({{PadPos{right_pos_i[aabb_ct_pkg::POS_W-1]}}, right_pos_i, 1'b0})
                 + $signed({{PadSize{1'b0}}, right_size_i});

  assign diff     = left_c - right_c;
  assign diff_neg = right_c - left_c;
  assign size_sum = $signed({{PadSize{1'b0}}, left_size_i})
                  + $signed({{PadSize{1'b0}}, right_size_i});

  assign overlap_o = (diff < size_sum) && (diff_neg < size_sum);

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_ct_contact_mem.sv =====
// contact bit memory with write forwarding and clearing sweep
`timescale 1ns / 1ps
`default_nettype none

module aabb_ct_contact_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                clear_start_i,
  output logic                                     busy_o,
  input  wire logic                                rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]            rd_addr_i,
  output logic                                     rd_bit_o,
  input  wire logic [$clog2(DEPTH)-1:0]            wr_addr_i,
  input  wire aabb_ct_pkg::pair_update_t           wr_i
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

  logic             mem [DEPTH];
  logic             rd_bit_q;
  logic             busy_q, busy_d;
  logic [AddrW-1:0] sweep_q, sweep_d;

  always_comb begin
    busy_d  = busy_q;
    sweep_d = sweep_q;
    if (clear_start_i) begin
      busy_d  = 1'b1;
      sweep_d = '0;
    end else if (busy_q) begin
      sweep_d = sweep_q + AddrW'(1);
      if (sweep_q == LastAddr) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else begin
      busy_q  <= busy_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[sweep_q] <= 1'b0;
    end else if (wr_i.wr_en) begin
      mem[wr_addr_i] <= wr_i.touching;
    end
  end

  // same-cycle write to the address being read wins
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.wr_en && (wr_addr_i == rd_addr_i)) begin
        rd_bit_q <= wr_i.touching;
      end else begin
        rd_bit_q <= mem[rd_addr_i];
      end
    end
  end

  assign busy_o   = busy_q;
  assign rd_bit_o = rd_bit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_contact_tracker.sv =====
// top level of the box contact tracker
// Usage:
//   pair_i carries one transaction per item: a clear command or an ordered
//   pair of collider ids with two boxes (signed Q15.8 corner, unsigned size).
//   result_o returns exactly one transaction per item, in order, with the
//   contact event (none, enter, stay, exit) and the strict overlap flag.
//   Each item passes the input stage register and then the result register.
//   One item can be accepted every cycle while no sweep runs and the
//   receiver takes results, set by the contact bit memory with one read and
//   one write port, whose read-modify-write is forwarded between
//   back-to-back items.
//   Ids at or above COLLIDER_IDS give an overlap flag but no event and no
//   state change; a clear returns none with overlap 0.
//   After reset and after each clear command the contact memory is swept,
//   one entry a cycle, over all COLLIDER_IDS*COLLIDER_IDS entries (4096 at the
//   default); pair_i.ready stays low during the sweep.
//   When the receiver stalls, the result register holds its transaction and
//   one more item waits in the input stage; pair_i.ready then drops.
`timescale 1ns / 1ps
`default_nettype none

module aabb_contact_tracker #(
  parameter int unsigned COLLIDER_IDS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  aabb_ct_pair_if.sink     pair_i,
  aabb_ct_result_if.source result_o
);

  localparam int unsigned Depth  = COLLIDER_IDS * COLLIDER_IDS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned LimitW = 9;
  localparam logic [LimitW-1:0] IdLimit = LimitW'(COLLIDER_IDS);

  logic pair_accept;
  logic s1_adv;
  logic mem_busy;
  logic rd_bit;

  logic                                  s1_valid_q;
  logic                                  s1_opcode_q;
  logic                                  s1_tracked_q;
  logic [AddrW-1:0]                      s1_addr_q;
  logic signed [aabb_ct_pkg::POS_W-1:0]  s1_left_x_q, s1_left_y_q;
  logic signed [aabb_ct_pkg::POS_W-1:0]  s1_right_x_q, s1_right_y_q;
  logic [aabb_ct_pkg::SIZE_W-1:0]        s1_left_w_q, s1_left_h_q;
  logic [aabb_ct_pkg::SIZE_W-1:0]        s1_right_w_q, s1_right_h_q;

  logic                                  out_valid_q, out_valid_d;
  aabb_ct_pkg::contact_event_e           out_event_q, ev_d;
  logic                                  out_overlap_q, overlap_d;

  logic                                  in_tracked;
  logic [AddrW-1:0]                      in_addr;
  logic                                  ov_x, ov_y, ov;
  aabb_ct_pkg::pair_update_t             wr;

  assign s1_adv       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign pair_i.ready = !mem_busy && (!s1_valid_q || s1_adv);
  assign pair_accept  = pair_i.valid && pair_i.ready;

  assign in_tracked = ({{(LimitW - aabb_ct_pkg::ID_W){1'b0}}, pair_i.left_id} < IdLimit)
                   && ({{(LimitW - aabb_ct_pkg::ID_W){1'b0}}, pair_i.right_id} < IdLimit);
  assign in_addr    = AddrW'(pair_i.left_id) * AddrW'(COLLIDER_IDS)
                    + AddrW'(pair_i.right_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pair_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_accept) begin
      s1_opcode_q  <= pair_i.opcode;
      s1_tracked_q <= in_tracked;
      s1_addr_q    <= in_addr;
      s1_left_x_q  <= pair_i.left_x;
      s1_left_y_q  <= pair_i.left_y;
      s1_left_w_q  <= pair_i.left_w;
      s1_left_h_q  <= pair_i.left_h;
      s1_right_x_q <= pair_i.right_x;
      s1_right_y_q <= pair_i.right_y;
      s1_right_w_q <= pair_i.right_w;
      s1_right_h_q <= pair_i.right_h;
    end
  end

  aabb_ct_axis u_axis_x (
    .left_pos_i   (s1_left_x_q),
    .left_size_i  (s1_left_w_q),
    .right_pos_i  (s1_right_x_q),
    .right_size_i (s1_right_w_q),
    .overlap_o    (ov_x)
  );

  aabb_ct_axis u_axis_y (
    .left_pos_i   (s1_left_y_q),
    .left_size_i  (s1_left_h_q),
    .right_pos_i  (s1_right_y_q),
    .right_size_i (s1_right_h_q),
    .overlap_o    (ov_y)
  );

  assign ov = ov_x && ov_y;

  always_comb begin
    ev_d      = aabb_ct_pkg::EV_NONE;
    overlap_d = 1'b0;
    if (s1_opcode_q == aabb_ct_pkg::OP_TEST) begin
      overlap_d = ov;
      if (s1_tracked_q) begin
        if (ov) begin
          ev_d = rd_bit ? aabb_ct_pkg::EV_STAY : aabb_ct_pkg::EV_ENTER;
        end else if (rd_bit) begin
          ev_d = aabb_ct_pkg::EV_EXIT;
        end
      end
    end
  end

  assign wr.wr_en    = s1_adv && (s1_opcode_q == aabb_ct_pkg::OP_TEST) && s1_tracked_q;
  assign wr.touching = ov;

  aabb_ct_contact_mem #(
    .DEPTH (Depth)
  ) u_contact_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_start_i (pair_accept && (pair_i.opcode == aabb_ct_pkg::OP_CLEAR)),
    .busy_o        (mem_busy),
    .rd_en_i       (pair_accept),
    .rd_addr_i     (in_addr),
    .rd_bit_o      (rd_bit),
    .wr_addr_i     (s1_addr_q),
    .wr_i          (wr)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_event_q   <= ev_d;
      out_overlap_q <= overlap_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.contact_event = out_event_q;
  assign result_o.boxes_overlap = out_overlap_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_ct_checker.sv =====
// port-level assertions for the box contact tracker and their bind
`timescale 1ns / 1ps
`default_nettype none

module aabb_ct_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          in_opcode_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [aabb_ct_pkg::EV_W-1:0]  out_event_i,
  input wire logic                          out_overlap_i
);

  // a held result stays valid with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable(out_event_i) && $stable(out_overlap_i))
    else $error("stalled result transaction changed");

  // enter and stay only come with overlapping boxes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_event_i == aabb_ct_pkg::EV_ENTER)
      || (out_event_i == aabb_ct_pkg::EV_STAY)) |-> out_overlap_i)
    else $error("enter or stay without overlap");

  // exit only comes with separated boxes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_event_i == aabb_ct_pkg::EV_EXIT) |-> !out_overlap_i)
    else $error("exit while boxes overlap");

  // a clear starts the sweep and blocks new transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == aabb_ct_pkg::OP_CLEAR) |=> !in_ready_i)
    else $error("input accepted right after a clear");

endmodule

bind aabb_contact_tracker aabb_ct_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pair_i.valid),
  .in_ready_i    (pair_i.ready),
  .in_opcode_i   (pair_i.opcode),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_event_i   (result_o.contact_event),
  .out_overlap_i (result_o.boxes_overlap)
);

`default_nettype wire
